@@ sv/morus640_keystream_round_assert.svh @@
// Assertion helpers for the MORUS-640 keystream round engine.
`ifndef MORUS640_KEYSTREAM_ROUND_ASSERT_SVH
`define MORUS640_KEYSTREAM_ROUND_ASSERT_SVH

// Checked out of reset only.
`define MKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define MKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/morus640_pkg.sv @@
`default_nettype none

package morus640_pkg;

  localparam int NumWords  = 5;
  localparam int NumHalves = 2 * NumWords;
  localparam int LaneW     = 32;
  localparam int NumLanes  = 4;
  localparam int HalfW     = 64;
  localparam int SlotW     = 4;
  localparam int WordIdxW  = $clog2(NumWords);

  typedef enum logic {
    ActLoad = 1'b0,
    ActStep = 1'b1
  } action_e;

  typedef logic [NumLanes-1:0][LaneW-1:0] word_t;
  typedef word_t [NumWords-1:0]           state_t;

  // Rotate each 32-bit lane left by r (r is always a constant in use).
  function automatic word_t lane_rotl(word_t w, int unsigned r);
    word_t o;
    for (int i = 0; i < NumLanes; i++) begin
      o[i] = (w[i] << r) | (w[i] >> (LaneW - r));
    end
    return o;
  endfunction

  // New lane i takes old lane (i + k) mod 4.
  function automatic word_t word_rot(word_t w, int unsigned k);
    word_t o;
    for (int i = 0; i < NumLanes; i++) begin
      o[i] = w[(i + k) % NumLanes];
    end
    return o;
  endfunction

  // One part of the state update with a zero message block.
  function automatic state_t upd_part(state_t s, int unsigned a, int unsigned b,
                                      int unsigned c, int unsigned d,
                                      int unsigned r, int unsigned p,
                                      int unsigned k);
    state_t o;
    o    = s;
    o[a] = lane_rotl(s[a] ^ s[d] ^ (s[b] & s[c]), r);
    o[p] = word_rot(o[p], k);
    return o;
  endfunction

  function automatic word_t keystream(state_t s);
    return s[0] ^ word_rot(s[1], 1) ^ (s[2] & s[3]);
  endfunction

  function automatic state_t state_update(state_t s);
    state_t t;
    t = upd_part(s, 0, 1, 2, 3,  5, 3, 3);
    t = upd_part(t, 1, 2, 3, 4, 31, 4, 2);
    t = upd_part(t, 2, 3, 4, 0,  7, 0, 1);
    t = upd_part(t, 3, 4, 0, 1, 22, 1, 2);
    t = upd_part(t, 4, 0, 1, 2, 13, 2, 3);
    return t;
  endfunction

endpackage

`default_nettype wire

@@ sv/morus640_keystream_round.sv @@
// MORUS-640 keystream round engine. Holds the five 128-bit state words.
// A request with tuser = 0 loads one 64-bit half-word (slot/2 selects the
// word, even slot = low half; slots 10..15 are ignored) and returns nothing.
// A request with tuser = 1 returns the keystream word of the current state
// and then applies one full five-part state update with a zero message.
// One request is taken every cycle while no step is held back. The round
// is five chained parts of XOR/AND logic with fixed rotations, a few gate
// levels between the request register and the state/result registers. A
// step passes the request register and then the result register before
// tvalid rises, and back-to-back steps chain through the state register
// without bubbles. While a result waits, loads keep flowing; a step holds in
// the request register until the waiting result is taken.
`default_nettype none

module morus640_keystream_round (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [71:0]  s_axis_tdata_i,   // [3:0] slot, [67:4] load_data, rest zero
  input  wire logic         s_axis_tuser_i,   // [0] action
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [127:0]      m_axis_tdata_o    // [63:0] keystream_lo, [127:64] keystream_hi
);

  logic                                   req_valid_q, req_valid_d;
  morus640_pkg::action_e                  req_action_q;
  logic [morus640_pkg::SlotW-1:0]         req_slot_q;
  logic [morus640_pkg::HalfW-1:0]         req_data_q;
  morus640_pkg::state_t                   state_q, state_d;
  logic                                   out_valid_q, out_valid_d;
  morus640_pkg::word_t                    out_data_q;
  logic                                   out_free, adv, in_acc;
  logic [morus640_pkg::WordIdxW-1:0]      word_idx;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign adv             = req_valid_q &&
                           (req_action_q == morus640_pkg::ActLoad || out_free);
  assign s_axis_tready_o = !req_valid_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign word_idx        = req_slot_q[morus640_pkg::SlotW-1:1];

  always_comb begin
    req_valid_d = in_acc || (req_valid_q && !adv);
    out_valid_d = out_valid_q && !m_axis_tready_i;
    state_d     = state_q;
    if (adv) begin
      case (req_action_q)
        morus640_pkg::ActStep: begin
          out_valid_d = 1'b1;
          state_d     = morus640_pkg::state_update(state_q);
        end
        morus640_pkg::ActLoad: begin
          if (req_slot_q < morus640_pkg::SlotW'(morus640_pkg::NumHalves)) begin
            if (req_slot_q[0]) begin
              state_d[word_idx][3:2] = req_data_q;
            end else begin
              state_d[word_idx][1:0] = req_data_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_action_q <= morus640_pkg::action_e'(s_axis_tuser_i);
      req_slot_q   <= s_axis_tdata_i[3:0];
      req_data_q   <= s_axis_tdata_i[67:4];
    end
    if (adv && req_action_q == morus640_pkg::ActStep) begin
      out_data_q <= morus640_pkg::keystream(state_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`include "morus640_keystream_round_assert.svh"

  `MKS_ASSERT_ALWAYS(a_reset_clear, !rst_ni |-> (!req_valid_q && !out_valid_q), "valid set in reset")
  `MKS_ASSERT(a_step_result, (adv && req_action_q == morus640_pkg::ActStep) |=> out_valid_q, "step lost its result")
  `MKS_ASSERT(a_load_quiet, (adv && req_action_q == morus640_pkg::ActLoad) |=> (out_valid_q == $past(out_valid_q && !m_axis_tready_i)), "load made a result")
  `MKS_ASSERT(a_stall_hold, (req_valid_q && !adv) |=> $stable(state_q), "state moved while stalled")
  `MKS_ASSERT(a_bad_slot, (adv && req_action_q == morus640_pkg::ActLoad && req_slot_q >= morus640_pkg::SlotW'(morus640_pkg::NumHalves)) |=> $stable(state_q), "out-of-range load wrote state")

endmodule

`default_nettype wire
